FILE: src/bsf_pkg.sv
// Shared constants, codes and types for the byte shuffle filter.
`timescale 1ns / 1ps

package bsf_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	// read pointer can run up to about twice the fill count
	localparam int PTR_W = CNT_W + 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_PULL = 1'b1
	} action_t;

	typedef enum logic {
		DIR_SHUFFLE = 1'b0,
		DIR_UNSHUFFLE = 1'b1
	} direction_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_LENGTH = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// one queued operation for the back end, with its result fields
	typedef struct packed {
		logic wr;
		logic rd;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
		logic last;
		status_t status;
	} bsf_entry_t;

endpackage

FILE: src/bsf_front.sv
// Front end: configuration, block bookkeeping and read address counters.
`timescale 1ns / 1ps

module bsf_front import bsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic accept,
	input logic action,
	input logic [7:0] data_byte,
	input logic last_byte,
	output bsf_entry_t entry
);

	logic [1:0] esize_code_q;
	direction_t dir_q;
	logic [CNT_W-1:0] fill_q, fill_n;
	logic ready_q, ready_n;
	logic ovf_q, ovf_n;
	logic [CNT_W-1:0] ec_q, ec_n;
	logic [CNT_W-1:0] pc_q, pc_n;
	logic [PTR_W-1:0] rp_q, rp_n;
	logic [CNT_W-1:0] pulled_q, pulled_n;

	logic [PTR_W-1:0] esize;
	logic [CNT_W-1:0] nelts;
	logic [CNT_W-1:0] fill_e;
	logic cfg_hit;

	assign esize = PTR_W'(1) << esize_code_q;
	assign nelts = fill_q >> esize_code_q;
	assign cfg_hit = cfg_we && (cfg_index == REG_ELEM_SIZE || cfg_index == REG_DIRECTION);

	always_comb begin
		fill_n = fill_q;
		ready_n = ready_q;
		ovf_n = ovf_q;
		ec_n = ec_q;
		pc_n = pc_q;
		rp_n = rp_q;
		pulled_n = pulled_q;
		fill_e = ready_q ? '0 : fill_q;
		entry = '0;
		entry.status = ST_OK;
		if (accept) begin
			if (action == ACT_PUSH) begin
				if (ready_q) begin
					// an unpulled block is dropped by a new push
					ovf_n = 1'b0;
					ec_n = '0;
					pc_n = '0;
					rp_n = '0;
					pulled_n = '0;
				end
				ready_n = 1'b0;
				if (fill_e < CNT_W'(BUFFER_BYTES)) begin
					entry.wr = 1'b1;
					entry.addr = fill_e[ADDR_W-1:0];
					entry.data = data_byte;
					fill_n = fill_e + CNT_W'(1);
				end else begin
					ovf_n = 1'b1;
					fill_n = fill_e;
					entry.status = ST_OVERFLOW;
				end
				if (last_byte) begin
					ec_n = '0;
					pc_n = '0;
					rp_n = '0;
					pulled_n = '0;
					if (ovf_n) begin
						fill_n = '0;
						ovf_n = 1'b0;
						entry.status = ST_OVERFLOW;
					end else if ((PTR_W'(fill_n) & (esize - PTR_W'(1))) != '0) begin
						fill_n = '0;
						entry.status = ST_LENGTH;
					end else begin
						ready_n = 1'b1;
					end
				end
			end else begin
				if (!ready_q) begin
					entry.status = ST_EMPTY;
				end else begin
					entry.rd = rp_q < PTR_W'(fill_q);
					entry.addr = rp_q[ADDR_W-1:0];
					if (dir_q == DIR_SHUFFLE) begin
						ec_n = ec_q + CNT_W'(1);
						rp_n = rp_q + esize;
						if ({1'b0, ec_q} + (CNT_W + 1)'(1) >= {1'b0, nelts}) begin
							ec_n = '0;
							pc_n = pc_q + CNT_W'(1);
							rp_n = PTR_W'(pc_n);
						end
					end else begin
						pc_n = pc_q + CNT_W'(1);
						rp_n = rp_q + PTR_W'(nelts);
						if (PTR_W'(pc_q) + PTR_W'(1) >= esize) begin
							pc_n = '0;
							ec_n = ec_q + CNT_W'(1);
							rp_n = PTR_W'(ec_n);
						end
					end
					pulled_n = pulled_q + CNT_W'(1);
					if (pulled_n >= fill_q) begin
						entry.last = 1'b1;
						ready_n = 1'b0;
						fill_n = '0;
						ec_n = '0;
						pc_n = '0;
						rp_n = '0;
						pulled_n = '0;
					end
				end
			end
		end
		// a register write restarts pulling from the first output byte
		if (cfg_hit) begin
			ec_n = '0;
			pc_n = '0;
			rp_n = '0;
			pulled_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esize_code_q <= 2'd2;
			dir_q <= DIR_SHUFFLE;
			fill_q <= '0;
			ready_q <= 1'b0;
			ovf_q <= 1'b0;
			ec_q <= '0;
			pc_q <= '0;
			rp_q <= '0;
			pulled_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ELEM_SIZE) begin
				esize_code_q <= cfg_wdata[1:0];
			end
			if (cfg_we && cfg_index == REG_DIRECTION) begin
				dir_q <= direction_t'(cfg_wdata[0]);
			end
			fill_q <= fill_n;
			ready_q <= ready_n;
			ovf_q <= ovf_n;
			ec_q <= ec_n;
			pc_q <= pc_n;
			rp_q <= rp_n;
			pulled_q <= pulled_n;
		end
	end

endmodule

FILE: src/bsf_queue.sv
// Small FIFO of operations between the front and back ends.
`timescale 1ns / 1ps

module bsf_queue import bsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bsf_entry_t push_entry,
	output logic full,
	input logic pop,
	output logic empty,
	output bsf_entry_t head
);

	bsf_entry_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

FILE: src/bsf_back.sv
// Back end: block buffer memory and the output register.
`timescale 1ns / 1ps

module bsf_back import bsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input bsf_entry_t q_head,
	output logic q_pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,
	output logic m_tlast,
	output logic [1:0] m_tuser
);

	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] rdata_s1;
	logic valid_s1;
	bsf_entry_t op_s1;

	assign q_pop = !q_empty && (!valid_s1 || m_tready);

	// operations run in queue order, so a read never sees a later write
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_head.wr) begin
				mem[q_head.addr] <= q_head.data;
			end
			rdata_s1 <= mem[q_head.addr];
			op_s1 <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata = op_s1.rd ? rdata_s1 : 8'd0;
	assign m_tlast = op_s1.last;
	assign m_tuser = op_s1.status;

endmodule

FILE: src/byte_shuffle_filter.sv
// Top level of the byte shuffle filter: front end, queue and back end.
`timescale 1ns / 1ps

// Byte-plane shuffle (direction 0) and unshuffle (direction 1) for elements of
// 1, 2, 4 or 8 bytes over blocks of up to BUFFER_BYTES bytes. Push items
// (s_tuser = 0) write one byte each; the push with s_tlast closes the block.
// Pull items (s_tuser = 1) return the transposed bytes one per item. Every
// item gives exactly one result whose m_tuser carries the status. The block
// takes one item per clock when the output is not stalled: the front end
// updates its counters as it accepts each item, and the back end performs
// one buffer access per cycle on its single memory port, with the read
// registered, so an item's result is presented from the output register
// once the item has passed through its queue slot. A four-entry queue
// between the two ends absorbs output stalls. The buffer needs no clearing
// after reset. Write configuration only while no item is in flight.
module byte_shuffle_filter import bsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] data_byte
	input logic s_tlast,
	input logic [0:0] s_tuser, // [0] action
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // [7:0] out_byte
	output logic m_tlast,
	output logic [1:0] m_tuser // [1:0] status
);

	logic accept;
	logic q_full, q_empty, q_pop;
	bsf_entry_t entry, q_head;

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	bsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.action(s_tuser[0]),
		.data_byte(s_tdata),
		.last_byte(s_tlast),
		.entry(entry)
	);

	bsf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_entry(entry),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.head(q_head)
	);

	bsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

`ifndef SYNTHESIS
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == 8'd0 && !m_tlast)
		else $error("non-ok result carries data or last");

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == ST_OK)
		else $error("last byte with error status");

	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !q_empty || m_tvalid)
		else $error("accepted item lost between queue and output");
`endif

endmodule
